// ===== design/maa_pkg.sv =====
// ----------------------------------------------------------------------------
// maa_pkg: shared types and constants of the array address unit
// Payload structs for both channels, the command word that travels from the
// front end to the back end, and the queue status bundle.
// ----------------------------------------------------------------------------
package maa_pkg;

  localparam int NUM_ARRAYS_DEF = 16;
  localparam int MAX_DIMS_DEF   = 10;
  localparam int CNT_W          = 4;
  localparam int QUEUE_DEPTH    = 2;

  // Input action codes. The fourth code has no meaning and is dropped.
  typedef enum logic [1:0] {
    ACT_HDR = 2'd0,
    ACT_BND = 2'd1,
    ACT_IDX = 2'd2
  } maa_act_e;

  // Command kinds as queued for the back end.
  typedef enum logic [1:0] {
    CMD_HDR = 2'd0,
    CMD_BND = 2'd1,
    CMD_IDX = 2'd2
  } maa_cmd_e;

  typedef struct packed {
    logic [1:0]        action;
    logic [3:0]        array_id;
    logic [3:0]        dim_pos;
    logic signed [31:0] base_addr;
    logic [15:0]       elem_size;
    logic [CNT_W-1:0]  dim_count;
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
    logic signed [31:0] index_value;
  } maa_in_t;

  typedef struct packed {
    logic signed [31:0] address;
    logic [3:0]        ref_array;
  } maa_out_t;

  // val_a carries the base address, the lower bound or the index value;
  // val_b carries the upper bound.
  typedef struct packed {
    maa_cmd_e         kind;
    logic [3:0]       array_id;
    logic [3:0]       dim_pos;
    logic [CNT_W-1:0] dim_count;
    logic [15:0]      elem_size;
    logic [31:0]      val_a;
    logic [31:0]      val_b;
  } maa_cmd_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } maa_q_stat_t;

endpackage

// ===== design/maa_front.sv =====
// ----------------------------------------------------------------------------
// maa_front: input classification
// Accepts input items, drops those that have no effect, clamps the dimension
// count of header items and turns the rest into queued commands.
// ----------------------------------------------------------------------------
module maa_front #(
  parameter int NUM_ARRAYS = maa_pkg::NUM_ARRAYS_DEF,
  parameter int MAX_DIMS   = maa_pkg::MAX_DIMS_DEF
) (
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  maa_pkg::maa_in_t     in_data_i,
  input  maa_pkg::maa_q_stat_t q_stat_i,
  output logic                 push_o,
  output maa_pkg::maa_cmd_t    cmd_o
);
  import maa_pkg::*;

  logic             keep;
  logic [CNT_W-1:0] count;

  assign in_stall_o = q_stat_i.full;

  always_comb begin
    keep          = 1'b0;
    count         = (in_data_i.dim_count == '0) ? CNT_W'(1) : in_data_i.dim_count;
    if (int'(count) > MAX_DIMS) begin
      count = CNT_W'(MAX_DIMS);
    end
    cmd_o.kind      = CMD_IDX;
    cmd_o.array_id  = in_data_i.array_id;
    cmd_o.dim_pos   = in_data_i.dim_pos;
    cmd_o.dim_count = count;
    cmd_o.elem_size = in_data_i.elem_size;
    cmd_o.val_a     = in_data_i.index_value;
    cmd_o.val_b     = in_data_i.upper_bound;
    case (in_data_i.action)
      ACT_HDR: begin
        keep        = 1'b1;
        cmd_o.kind  = CMD_HDR;
        cmd_o.val_a = in_data_i.base_addr;
      end
      ACT_BND: begin
        keep        = int'(in_data_i.dim_pos) < MAX_DIMS;
        cmd_o.kind  = CMD_BND;
        cmd_o.val_a = in_data_i.lower_bound;
      end
      ACT_IDX: begin
        keep        = 1'b1;
        cmd_o.kind  = CMD_IDX;
      end
      default: begin
        keep        = 1'b0;
      end
    endcase
    if (int'(in_data_i.array_id) >= NUM_ARRAYS) begin
      keep = 1'b0;
    end
  end

  // A dropped item is still a completed transfer; it simply queues nothing.
  assign push_o = in_valid_i && !q_stat_i.full && keep;

endmodule

// ===== design/maa_queue.sv =====
// ----------------------------------------------------------------------------
// maa_queue: command queue
// A short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module maa_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  maa_pkg::maa_cmd_t    cmd_i,
  input  logic                 pop_i,
  output maa_pkg::maa_cmd_t    head_o,
  output maa_pkg::maa_q_stat_t q_stat_o
);
  import maa_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  maa_cmd_t          entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_QW-1:0] count_q, count_d;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign head_o             = entry_q[rd_ptr_q];
  assign q_stat_o.full      = (count_q == CNT_QW'(QUEUE_DEPTH));
  assign q_stat_o.not_empty = (count_q != '0);

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_QW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== design/maa_back.sv =====
// ----------------------------------------------------------------------------
// maa_back: descriptor tables and address arithmetic
// Executes queued commands in order: a table write is done on its pop, an
// index goes through a table read, an extent step and a multiply-accumulate
// and the last index of a reference adds a scale step and the output load.
// ----------------------------------------------------------------------------
module maa_back #(
  parameter int NUM_ARRAYS = maa_pkg::NUM_ARRAYS_DEF,
  parameter int MAX_DIMS   = maa_pkg::MAX_DIMS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  maa_pkg::maa_q_stat_t q_stat_i,
  input  maa_pkg::maa_cmd_t    cmd_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output maa_pkg::maa_out_t    out_data_o
);
  import maa_pkg::*;

  localparam int AW    = (NUM_ARRAYS > 1) ? $clog2(NUM_ARRAYS) : 1;
  localparam int SLOTS = NUM_ARRAYS * MAX_DIMS;
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CW    = CNT_W + 1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXT   = 5'b00010,
    ST_MAC   = 5'b00100,
    ST_SCALE = 5'b01000,
    ST_EMIT  = 5'b10000
  } back_state_e;

  typedef struct packed {
    logic [31:0]      base;
    logic [15:0]      size;
    logic [CNT_W-1:0] dims;
  } hdr_t;

  typedef struct packed {
    logic [31:0] lower;
    logic [31:0] upper;
  } bnd_t;

  hdr_t hdr_mem [NUM_ARRAYS];
  bnd_t bnd_mem [SLOTS];
  hdr_t hdr_rd_q;
  bnd_t bnd_rd_q;

  back_state_e state_q, state_d;
  logic [31:0] acc_q, acc_d;
  logic [PW-1:0] pos_q, pos_d;
  logic        out_valid_q, out_valid_d;
  maa_out_t    out_q;
  logic [31:0] idx_q, ext_q, diff_q, fold_q, scaled_q;
  logic [3:0]  id_q;
  logic        last_q;

  logic          hdr_we, hdr_re, bnd_we, bnd_re;
  logic [AW-1:0] hdr_addr;
  logic [SW-1:0] bnd_addr;
  logic [31:0]   acc_new;
  logic          emit;

  assign pop_o    = (state_q == ST_IDLE) && q_stat_i.not_empty;
  assign hdr_addr = AW'(cmd_i.array_id);
  assign hdr_we   = pop_o && (cmd_i.kind == CMD_HDR);
  assign bnd_we   = pop_o && (cmd_i.kind == CMD_BND);
  assign hdr_re   = pop_o && (cmd_i.kind == CMD_IDX);
  assign bnd_re   = hdr_re;

  always_comb begin
    if (cmd_i.kind == CMD_BND) begin
      bnd_addr = SW'(int'(cmd_i.array_id) * MAX_DIMS + int'(cmd_i.dim_pos));
    end else begin
      bnd_addr = SW'(int'(cmd_i.array_id) * MAX_DIMS + int'(pos_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_mem[hdr_addr] <= '{base: cmd_i.val_a, size: cmd_i.elem_size,
                             dims: cmd_i.dim_count};
    end
    if (hdr_re) begin
      hdr_rd_q <= hdr_mem[hdr_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (bnd_we) begin
      bnd_mem[bnd_addr] <= '{lower: cmd_i.val_a, upper: cmd_i.val_b};
    end
    if (bnd_re) begin
      bnd_rd_q <= bnd_mem[bnd_addr];
    end
  end

  assign acc_new = acc_q * ext_q + diff_q;
  assign emit    = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    pos_d       = pos_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (hdr_re) begin
          state_d = ST_EXT;
        end
      end
      ST_EXT: begin
        state_d = ST_MAC;
      end
      ST_MAC: begin
        // The completing index clears the fold for the next reference.
        if (last_q) begin
          acc_d   = '0;
          pos_d   = '0;
          state_d = ST_SCALE;
        end else begin
          acc_d   = acc_new;
          pos_d   = pos_q + PW'(1);
          state_d = ST_IDLE;
        end
      end
      ST_SCALE: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_re) begin
      idx_q <= cmd_i.val_a;
      id_q  <= cmd_i.array_id;
    end
    if (state_q == ST_EXT) begin
      ext_q  <= bnd_rd_q.upper - bnd_rd_q.lower + 32'd1;
      diff_q <= idx_q - bnd_rd_q.lower;
      last_q <= (CW'(pos_q) + CW'(1)) >= CW'(hdr_rd_q.dims);
    end
    if (state_q == ST_MAC) begin
      fold_q <= acc_new;
    end
    if (state_q == ST_SCALE) begin
      scaled_q <= {16'b0, hdr_rd_q.size} * fold_q;
    end
    if (emit) begin
      out_q.address   <= hdr_rd_q.base + scaled_q;
      out_q.ref_array <= id_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/multidim_array_address.sv =====
// ----------------------------------------------------------------------------
// multidim_array_address: row-major array element address unit
// Holds array descriptors and turns runs of subscripts into byte addresses.
// ----------------------------------------------------------------------------
// Usage: items enter on the in channel (valid/stall) and are either header
// definitions, bound definitions for one dimension, or one subscript of a
// reference, leftmost first. After the last subscript of a reference one
// result leaves on the out channel: base + size * row-major offset, wrapping
// at 32 bits, tagged with the array id. Each transfer happens on a rising
// edge with valid high and stall low.
// Execution: a two-entry command queue decouples input from the execution
// engine. The engine performs a table write as it takes the command; a
// subscript that does not finish a reference passes through a table read,
// an extent step and a multiply-accumulate, and the final subscript adds a
// scale step and the output load. The engine takes no new command until it
// has finished the last one, so the sustained rate depends on the mix.
// Reset clears the fold and position state and empties the queue;
// descriptor tables are not cleared and must be defined before use. While
// the receiver stalls, the result holds, the engine waits at its output
// step and the queue fills, after which the input is stalled.
// ----------------------------------------------------------------------------
module multidim_array_address #(
  parameter int NUM_ARRAYS = maa_pkg::NUM_ARRAYS_DEF,
  parameter int MAX_DIMS   = maa_pkg::MAX_DIMS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  maa_pkg::maa_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output maa_pkg::maa_out_t out_data_o
);
  import maa_pkg::*;

  maa_q_stat_t q_stat;
  maa_cmd_t    push_cmd, head_cmd;
  logic        push, pop;

  maa_front #(
    .NUM_ARRAYS(NUM_ARRAYS),
    .MAX_DIMS  (MAX_DIMS)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .q_stat_i  (q_stat),
    .push_o    (push),
    .cmd_o     (push_cmd)
  );

  maa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .head_o  (head_cmd),
    .q_stat_o(q_stat)
  );

  maa_back #(
    .NUM_ARRAYS(NUM_ARRAYS),
    .MAX_DIMS  (MAX_DIMS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_stat_i   (q_stat),
    .cmd_i      (head_cmd),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // The front end must never write into a full queue.
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("command pushed into a full queue");

  // The engine must only take commands that are present.
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_stat.not_empty)
    else $error("command popped from an empty queue");

  // A result is never loaded in the same cycle as a queue pop.
  a_out_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!pop))
    else $error("result loaded in the same cycle as a queue pop");

endmodule

// ===== tb/maa_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// maa_tb_pkg: address prediction and result checking for the array unit
// Keeps a private copy of the descriptor tables and of the subscript fold,
// predicts one address per completed reference and checks the results of
// the block in order against those predictions.
// ----------------------------------------------------------------------------
package maa_tb_pkg;
  import maa_pkg::*;

  localparam int N_ARR = NUM_ARRAYS_DEF;
  localparam int N_DIM = MAX_DIMS_DEF;

  // The fourth action code carries no meaning and must be dropped by the block.
  localparam logic [1:0] ACT_NONE = 2'd3;

  class addr_scoreboard;
    logic [31:0] base_tbl [N_ARR];
    logic [15:0] size_tbl [N_ARR];
    logic [3:0]  dims_tbl [N_ARR];
    logic [31:0] lo_tbl   [N_ARR*N_DIM];
    logic [31:0] hi_tbl   [N_ARR*N_DIM];
    logic [31:0] fold_acc;
    int          fold_pos;
    maa_out_t    addr_due [$];
    int          errors;

    function new();
      foreach (base_tbl[i]) begin
        base_tbl[i] = '0;
        size_tbl[i] = '0;
        dims_tbl[i] = '0;
      end
      foreach (lo_tbl[i]) begin
        lo_tbl[i] = '0;
        hi_tbl[i] = '0;
      end
      fold_acc = '0;
      fold_pos = 0;
      errors   = 0;
    endfunction

    function void report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endfunction

    // Applies one accepted input transfer and queues the address it completes.
    function void note_item(maa_in_t it);
      int          id;
      int          p;
      int          slot;
      logic [31:0] extent;
      maa_out_t    res;
      id = int'(it.array_id);
      case (it.action)
        ACT_HDR: begin
          base_tbl[id] = it.base_addr;
          size_tbl[id] = it.elem_size;
          if (it.dim_count < 1) dims_tbl[id] = 4'd1;
          else if (it.dim_count > N_DIM) dims_tbl[id] = 4'(N_DIM);
          else dims_tbl[id] = it.dim_count;
        end
        ACT_BND: begin
          if (it.dim_pos < N_DIM) begin
            slot = id * N_DIM + int'(it.dim_pos);
            lo_tbl[slot] = it.lower_bound;
            hi_tbl[slot] = it.upper_bound;
          end
        end
        ACT_IDX: begin
          p = (fold_pos >= N_DIM) ? N_DIM - 1 : fold_pos;
          slot = id * N_DIM + p;
          extent = hi_tbl[slot] - lo_tbl[slot] + 32'd1;
          fold_acc = fold_acc * extent + (it.index_value - lo_tbl[slot]);
          if (p + 1 >= int'(dims_tbl[id])) begin
            res.address   = base_tbl[id] + {16'd0, size_tbl[id]} * fold_acc;
            res.ref_array = it.array_id;
            addr_due = {addr_due, res};
            fold_acc = '0;
            fold_pos = 0;
          end else begin
            fold_pos = (p + 1) % 16;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_addr(maa_out_t got);
      maa_out_t want;
      if (addr_due.size() == 0) begin
        report($sformatf("unexpected address %h for array %0d",
                         got.address, got.ref_array));
        return;
      end
      want = addr_due.pop_front();
      if (got.address !== want.address)
        report($sformatf("address %h, expected %h (array %0d)",
                         got.address, want.address, want.ref_array));
      if (got.ref_array !== want.ref_array)
        report($sformatf("array id %0d, expected %0d",
                         got.ref_array, want.ref_array));
    endfunction
  endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the row-major array address unit
// Defines array descriptors, then streams references through the block with
// random gaps and receiver stalls, one long receiver hold-off included, and
// checks every address against an independent prediction.
// ----------------------------------------------------------------------------
module tb;
  import maa_pkg::*;
  import maa_tb_pkg::*;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  maa_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  maa_out_t out_data_o;

  addr_scoreboard sb;

  // Shadow of what the stimulus has written, so that no unwritten entry is read.
  bit          hdr_ok [N_ARR];
  bit          bnd_ok [N_ARR*N_DIM];
  int          sh_dims [N_ARR];
  logic [31:0] sh_lo [N_ARR*N_DIM];
  logic [31:0] sh_hi [N_ARR*N_DIM];
  int          sh_pos;
  int          idle_mode;
  int          items_sent;
  bit          hold_go;

  multidim_array_address u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int clamp_pos(int p);
    return (p >= N_DIM) ? N_DIM - 1 : p;
  endfunction

  function automatic maa_in_t rand_item();
    logic [191:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    return maa_in_t'(raw[$bits(maa_in_t)-1:0]);
  endfunction

  function automatic int pick_gap();
    int r;
    if (idle_mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic bit idx_ok(int id);
    return hdr_ok[id] && bnd_ok[id * N_DIM + clamp_pos(sh_pos)];
  endfunction

  function automatic bit full_ok(int id);
    if (!hdr_ok[id]) return 1'b0;
    for (int d = 0; d < sh_dims[id]; d++)
      if (!bnd_ok[id * N_DIM + d]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [15:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'd0;
    if (r < 20) return 16'hFFFF;
    if (r < 70) return 16'($urandom_range(1, 16));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic void pick_bounds(output logic [31:0] lo, output logic [31:0] hi);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      lo = 32'($urandom_range(0, 40)) - 32'd20;
      hi = lo + 32'($urandom_range(0, 9));
    end else if (r < 85) begin
      lo = $urandom;
      hi = lo + 32'($urandom_range(0, 200));
    end else begin
      lo = $urandom;
      hi = $urandom;
    end
  endfunction

  function automatic logic [31:0] pick_index(int id);
    int          slot;
    int          r;
    logic [31:0] ext;
    slot = id * N_DIM + clamp_pos(sh_pos);
    ext = sh_hi[slot] - sh_lo[slot];
    r = $urandom_range(0, 99);
    if (r < 75)
      return sh_lo[slot] + ((ext <= 32'd1000) ? 32'($urandom_range(0, ext))
                                               : 32'($urandom_range(0, 1000)));
    if (r < 80) return sh_lo[slot];
    if (r < 85) return sh_hi[slot];
    return $urandom;
  endfunction

  // Offers one item and returns once the transfer has taken place.
  task automatic send_item(maa_in_t it);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_item(it);
    if (it.action != ACT_NONE) items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_hdr(int id, logic [31:0] base, logic [15:0] size, int cnt);
    maa_in_t it;
    it = rand_item();
    it.action    = ACT_HDR;
    it.array_id  = 4'(id);
    it.base_addr = base;
    it.elem_size = size;
    it.dim_count = 4'(cnt);
    hdr_ok[id] = 1'b1;
    if (it.dim_count < 1) sh_dims[id] = 1;
    else if (it.dim_count > N_DIM) sh_dims[id] = N_DIM;
    else sh_dims[id] = int'(it.dim_count);
    send_item(it);
  endtask

  task automatic send_bnd(int id, int d, logic [31:0] lo, logic [31:0] hi);
    maa_in_t it;
    it = rand_item();
    it.action      = ACT_BND;
    it.array_id    = 4'(id);
    it.dim_pos     = 4'(d);
    it.lower_bound = lo;
    it.upper_bound = hi;
    if (d < N_DIM) begin
      bnd_ok[id * N_DIM + d] = 1'b1;
      sh_lo[id * N_DIM + d]  = lo;
      sh_hi[id * N_DIM + d]  = hi;
    end
    send_item(it);
  endtask

  task automatic send_idx(int id, logic [31:0] v);
    maa_in_t it;
    int      p;
    it = rand_item();
    it.action      = ACT_IDX;
    it.array_id    = 4'(id);
    it.index_value = v;
    p = clamp_pos(sh_pos);
    sh_pos = (p + 1 >= sh_dims[id]) ? 0 : p + 1;
    send_item(it);
  endtask

  task automatic send_void();
    maa_in_t it;
    it = rand_item();
    it.action = ACT_NONE;
    send_item(it);
  endtask

  // A negative count asks for a random one, mostly small.
  task automatic define_array(int id, int cnt);
    int          r;
    logic [31:0] lo;
    logic [31:0] hi;
    if (cnt < 0) begin
      r = $urandom_range(0, 99);
      if (r < 70) cnt = $urandom_range(1, 4);
      else if (r < 90) cnt = $urandom_range(5, 10);
      else cnt = $urandom_range(0, 15);
    end
    send_hdr(id, $urandom, pick_size(), cnt);
    for (int d = 0; d < sh_dims[id]; d++) begin
      pick_bounds(lo, hi);
      send_bnd(id, d, lo, hi);
    end
  endtask

  task automatic send_noise();
    int          id;
    logic [31:0] lo;
    logic [31:0] hi;
    id = $urandom_range(0, N_ARR - 1);
    case ($urandom_range(0, 5))
      0: send_void();
      1: begin
        pick_bounds(lo, hi);
        send_bnd(id, $urandom_range(N_DIM, 15), lo, hi);
      end
      2: send_hdr(id, $urandom, pick_size(), $urandom_range(0, 15));
      3: begin
        pick_bounds(lo, hi);
        send_bnd(id, $urandom_range(0, N_DIM - 1), lo, hi);
      end
      default: begin
        // A subscript of a random array inside the reference in progress.
        if (idx_ok(id)) send_idx(id, pick_index(id));
        else send_void();
      end
    endcase
  endtask

  // Completes any reference left open, with whatever array can be read safely.
  task automatic finish_ref();
    int  id;
    bit  found;
    while (sh_pos != 0) begin
      found = 1'b0;
      for (int k = 0; k < 32 && !found; k++) begin
        id = $urandom_range(0, N_ARR - 1);
        found = idx_ok(id);
      end
      if (found) send_idx(id, pick_index(id));
      else define_array($urandom_range(0, N_ARR - 1), N_DIM);
    end
  endtask

  task automatic run_ref(int id);
    finish_ref();
    forever begin
      if ($urandom_range(0, 9) == 0) send_noise();
      if (!idx_ok(id)) break;
      send_idx(id, pick_index(id));
      if (sh_pos == 0) break;
    end
    finish_ref();
  endtask

  // Result side: random stalls, one long hold-off, and checking of transfers.
  initial begin
    int hold_left;
    int stall_left;
    int r;
    bit hold_done;
    hold_left = 0;
    stall_left = 0;
    hold_done = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) sb.check_addr(out_data_o);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
        if (idle_mode != 0) begin
          r = $urandom_range(0, 99);
          if (r < 20) stall_left = $urandom_range(1, 3);
          else if (r < 24) stall_left = $urandom_range(8, 40);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int id;
    int tries;
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    idle_mode = 0;
    items_sent = 0;
    hold_go = 1'b0;
    sh_pos = 0;
    foreach (hdr_ok[i]) begin
      hdr_ok[i] = 1'b0;
      sh_dims[i] = 1;
    end
    foreach (bnd_ok[i]) bnd_ok[i] = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extreme base, size and bounds; the full signed range has a zero extent.
    send_hdr(0, 32'h7FFF_FFFF, 16'hFFFF, 1);
    send_bnd(0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_idx(0, 32'h7FFF_FFFF);
    // A count of zero is stored as one; an index outside its bounds still folds.
    send_hdr(1, 32'h8000_0000, 16'd0, 0);
    send_bnd(1, 0, 32'd0, 32'd0);
    send_bnd(1, 1, 32'd5, 32'd9);
    send_idx(1, 32'hFFFF_FFFF);
    send_void();
    send_bnd(1, 15, 32'h8000_0000, 32'h7FFF_FFFF);
    send_hdr(2, 32'd1000, 16'd4, 3);
    send_bnd(2, 0, -32'sd2, 32'sd1);
    send_bnd(2, 1, 32'd1, 32'd3);
    send_bnd(2, 2, 32'd0, 32'd4);
    send_idx(2, 32'd0);
    // Array 1 takes the shared position and completes the reference of array 2.
    send_idx(1, 32'd7);
    send_idx(2, 32'd1);
    send_idx(2, 32'd2);
    // The count shrinks mid-reference, so the next subscript ends it.
    send_hdr(2, 32'd1000, 16'd4, 2);
    send_idx(2, 32'd3);
    send_hdr(15, 32'hFFFF_FFFF, 16'd1, 15);
    send_bnd(15, 9, 32'h7FFF_FFFF, 32'h8000_0000);
    send_idx(1, 32'h7FFF_FFFF);

    for (int a = 0; a < N_ARR; a++) define_array(a, -1);

    while (items_sent < 1800) begin
      if (items_sent % 150 < 5) idle_mode = $urandom_range(0, 2);
      if (!hold_go && items_sent > 600) hold_go = 1'b1;
      if ($urandom_range(0, 19) == 0) define_array($urandom_range(0, N_ARR - 1), -1);
      tries = 0;
      do begin
        id = $urandom_range(0, N_ARR - 1);
        tries++;
      end while (!full_ok(id) && tries < 32);
      if (!full_ok(id)) define_array(id, -1);
      run_ref(id);
    end
    in_valid_i <= 1'b0;

    while (sb.addr_due.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
